// File: src/aair_pkg.sv
// ----------------------------------------------------------------------------
// AABB integrate and resolve: shared package
// Item types, action and push codes, configuration bundle, fixed-point helpers.
// ----------------------------------------------------------------------------
package aair_pkg;

   // Action codes carried by an input item.
   localparam logic [1:0] ACT_SET_POS   = 2'd0;
   localparam logic [1:0] ACT_SET_VEL   = 2'd1;
   localparam logic [1:0] ACT_INTEGRATE = 2'd2;
   localparam logic [1:0] ACT_RESOLVE   = 2'd3;

   // Push axis codes reported with every result.
   localparam logic [1:0] AXIS_NONE  = 2'd0;
   localparam logic [1:0] AXIS_HORIZ = 2'd1;
   localparam logic [1:0] AXIS_VERT  = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_BASE_WIDTH    = 3'd0;
   localparam logic [2:0] REG_BASE_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_REDUCE_LEFT   = 3'd2;
   localparam logic [2:0] REG_REDUCE_TOP    = 3'd3;
   localparam logic [2:0] REG_REDUCE_RIGHT  = 3'd4;
   localparam logic [2:0] REG_REDUCE_BOTTOM = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Time step of 1/60 s as a multiply by 1092 and a shift right by 16.
   localparam logic signed [12:0] DT_MUL = 13'sd1092;
   localparam int                 SCALED_W = 27;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic signed [31:0] other_left;
      logic signed [31:0] other_top;
      logic [19:0]        other_span_x;
      logic [19:0]        other_span_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_vel_x;
      logic signed [31:0] out_vel_y;
      logic signed [31:0] out_box_left;
      logic signed [31:0] out_box_top;
      logic [19:0]        out_box_width;
      logic [19:0]        out_box_height;
      logic [1:0]         push_axis;
   } rsp_type;

   typedef struct packed {
      logic [11:0] base_width;
      logic [11:0] base_height;
      logic [15:0] reduce_left;
      logic [15:0] reduce_top;
      logic [15:0] reduce_right;
      logic [15:0] reduce_bottom;
   } cfg_type;

   // One classified item as it waits in the queue between front and back.
   typedef struct packed {
      logic [1:0]                  action;
      logic signed [31:0]          value_x;
      logic signed [31:0]          value_y;
      logic signed [SCALED_W-1:0]  step_x;      // value_x scaled by the time step
      logic signed [SCALED_W-1:0]  step_y;
      logic signed [31:0]          other_left;
      logic signed [31:0]          other_top;
      logic signed [32:0]          other_right;  // left + width
      logic signed [32:0]          other_bottom; // top + height
      logic signed [33:0]          other_cx2;    // twice the center x
      logic signed [33:0]          other_cy2;    // twice the center y
      logic [19:0]                 span_x;
      logic [19:0]                 span_y;
   } entry_type;

   // Multiply by 1092 and shift right by 16, rounding toward minus infinity.
   function automatic logic signed [SCALED_W-1:0] scale_dt(input logic signed [31:0] v);
      logic signed [43:0] prod;
      prod = 44'(v) * 44'(DT_MUL);
      return prod[42:16];
   endfunction

   // Saturate a 33 bit signed sum to 32 bits.
   function automatic logic signed [31:0] sat_to_32(input logic signed [32:0] s);
      logic signed [31:0] r;
      if (s[32] != s[31]) begin
         r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

endpackage

// File: src/aair_queue.sv
// ----------------------------------------------------------------------------
// AABB integrate and resolve: item queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module aair_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aair_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output aair_pkg::entry_type head
);
   import aair_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/aair_front.sv
// ----------------------------------------------------------------------------
// AABB integrate and resolve: front end
// Accepts items, scales step inputs and derives the other box's edges.
// ----------------------------------------------------------------------------
module aair_front (
   input  logic                req_valid,
   output logic                req_stall,
   input  aair_pkg::req_type   req_data,
   input  logic                queue_full,
   output logic                push,
   output aair_pkg::entry_type push_data
);
   import aair_pkg::*;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_data              = '0;
      push_data.action       = req_data.action;
      push_data.value_x      = req_data.value_x;
      push_data.value_y      = req_data.value_y;
      push_data.other_left   = req_data.other_left;
      push_data.other_top    = req_data.other_top;
      push_data.span_x       = req_data.other_span_x;
      push_data.span_y       = req_data.other_span_y;
      // Only an integrate item needs the scaled input; others leave zero.
      if (req_data.action == ACT_INTEGRATE) begin
         push_data.step_x = scale_dt(req_data.value_x);
         push_data.step_y = scale_dt(req_data.value_y);
      end
      if (req_data.action == ACT_RESOLVE) begin
         push_data.other_right  = 33'(req_data.other_left)
                                  + $signed(33'(req_data.other_span_x));
         push_data.other_bottom = 33'(req_data.other_top)
                                  + $signed(33'(req_data.other_span_y));
         push_data.other_cx2    = 34'($signed({req_data.other_left, 1'b0}))
                                  + $signed(34'(req_data.other_span_x));
         push_data.other_cy2    = 34'($signed({req_data.other_top, 1'b0}))
                                  + $signed(34'(req_data.other_span_y));
      end
   end

endmodule

// File: src/aair_exec.sv
// ----------------------------------------------------------------------------
// AABB integrate and resolve: back end
// Holds the body state, steps each item through its sequence, registers results.
// ----------------------------------------------------------------------------
module aair_exec (
   input  logic                clock,
   input  logic                reset,
   input  aair_pkg::cfg_type   cfg,
   input  logic                head_valid,
   input  aair_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output aair_pkg::rsp_type   rsp_data
);
   import aair_pkg::*;

   localparam logic [1:0] ST_A = 2'd0;
   localparam logic [1:0] ST_B = 2'd1;
   localparam logic [1:0] ST_C = 2'd2;
   localparam logic [1:0] ST_D = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic signed [31:0]         pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0]         vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [31:0]         box_l_ff, box_l_in, box_t_ff, box_t_in;
   logic [19:0]                box_w_ff, box_w_in, box_h_ff, box_h_in;
   logic signed [SCALED_W-1:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic                       apart_ff, apart_in;
   logic signed [35:0]         dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [20:0]                sumw_ff, sumw_in, sumh_ff, sumh_in;
   logic signed [36:0]         h2_ff, h2_in, v2_ff, v2_in;
   logic [1:0]                 axis_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic                       out_free, last_step, fire;
   logic signed [33:0]         my_right, my_bottom;
   logic signed [34:0]         my_cx2, my_cy2;
   logic signed [35:0]         abs_x, abs_y;
   logic [21:0]                push_d;
   logic signed [21:0]         size_w, size_h;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // An item ends after one step for loads, three for resolve, four for integrate.
   always_comb begin
      last_step = 1'b0;
      case (head.action) inside
         ACT_SET_POS, ACT_SET_VEL: last_step = (state_ff == ST_A);
         ACT_INTEGRATE:            last_step = (state_ff == ST_D);
         default:                  last_step = (state_ff == ST_C);
      endcase
   end

   assign fire = head_valid && last_step && out_free;
   assign pop  = fire;

   // Geometry of the body's box used by the separating axis test.
   assign my_right  = 34'(box_l_ff) + $signed(34'(box_w_ff));
   assign my_bottom = 34'(box_t_ff) + $signed(34'(box_h_ff));
   assign my_cx2    = 35'($signed({box_l_ff, 1'b0})) + $signed(35'(box_w_ff));
   assign my_cy2    = 35'($signed({box_t_ff, 1'b0})) + $signed(35'(box_h_ff));
   assign abs_x     = dx2_ff[35] ? -dx2_ff : dx2_ff;
   assign abs_y     = dy2_ff[35] ? -dy2_ff : dy2_ff;

   assign size_w = $signed({2'b00, cfg.base_width, 8'h00})
                   - $signed(22'(cfg.reduce_left)) - $signed(22'(cfg.reduce_right));
   assign size_h = $signed({2'b00, cfg.base_height, 8'h00})
                   - $signed(22'(cfg.reduce_top)) - $signed(22'(cfg.reduce_bottom));

   // Penetration depth is at most about 2^20 when the boxes overlap.
   assign push_d = (h2_ff < v2_ff) ? 22'((23'(h2_ff[21:0]) + 23'd1) >> 1)
                                   : 22'((23'(v2_ff[21:0]) + 23'd1) >> 1);

   always_comb begin
      state_in  = state_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      vel_x_in  = vel_x_ff;
      vel_y_in  = vel_y_ff;
      box_l_in  = box_l_ff;
      box_t_in  = box_t_ff;
      box_w_in  = box_w_ff;
      box_h_in  = box_h_ff;
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      apart_in  = apart_ff;
      dx2_in    = dx2_ff;
      dy2_in    = dy2_ff;
      sumw_in   = sumw_ff;
      sumh_in   = sumh_ff;
      h2_in     = h2_ff;
      v2_in     = v2_ff;
      axis_in   = AXIS_NONE;

      if (head_valid) begin
         case (head.action)
            ACT_SET_POS: begin
               if (fire) begin
                  pos_x_in = head.value_x;
                  pos_y_in = head.value_y;
                  box_l_in = head.value_x;
                  box_t_in = head.value_y;
               end
            end
            ACT_SET_VEL: begin
               if (fire) begin
                  vel_x_in = head.value_x;
                  vel_y_in = head.value_y;
               end
            end
            ACT_INTEGRATE: begin
               unique case (state_ff)
                  ST_A: begin
                     vel_x_in = sat_to_32(33'(vel_x_ff) + 33'(head.step_x));
                     vel_y_in = sat_to_32(33'(vel_y_ff) + 33'(head.step_y));
                     state_in = ST_B;
                  end
                  ST_B: begin
                     prod_x_in = scale_dt(vel_x_ff);
                     prod_y_in = scale_dt(vel_y_ff);
                     state_in  = ST_C;
                  end
                  ST_C: begin
                     pos_x_in = sat_to_32(33'(pos_x_ff) + 33'(prod_x_ff));
                     pos_y_in = sat_to_32(33'(pos_y_ff) + 33'(prod_y_ff));
                     state_in = ST_D;
                  end
                  ST_D: begin
                     if (fire) begin
                        box_l_in = sat_to_32(33'(pos_x_ff)
                                             + $signed(33'(cfg.reduce_left)));
                        box_t_in = sat_to_32(33'(pos_y_ff)
                                             + $signed(33'(cfg.reduce_top)));
                        box_w_in = size_w[21] ? '0 : size_w[19:0];
                        box_h_in = size_h[21] ? '0 : size_h[19:0];
                        state_in = ST_A;
                     end
                  end
                  default: state_in = ST_A;
               endcase
            end
            default: begin
               unique case (state_ff)
                  ST_A: begin
                     apart_in = (my_right < 34'(head.other_left))
                                || (34'(head.other_right) < 34'(box_l_ff))
                                || (my_bottom < 34'(head.other_top))
                                || (34'(head.other_bottom) < 34'(box_t_ff));
                     dx2_in   = 36'(head.other_cx2) - 36'(my_cx2);
                     dy2_in   = 36'(head.other_cy2) - 36'(my_cy2);
                     sumw_in  = 21'(head.span_x) + 21'(box_w_ff);
                     sumh_in  = 21'(head.span_y) + 21'(box_h_ff);
                     state_in = ST_B;
                  end
                  ST_B: begin
                     h2_in    = $signed(37'(sumw_ff)) - 37'(abs_x);
                     v2_in    = $signed(37'(sumh_ff)) - 37'(abs_y);
                     state_in = ST_C;
                  end
                  ST_C: begin
                     if (fire) begin
                        state_in = ST_A;
                        if (!apart_ff) begin
                           if (h2_ff < v2_ff) begin
                              axis_in = AXIS_HORIZ;
                              // A positive doubled offset means the body is left of center.
                              if (dx2_ff > 0) begin
                                 box_l_in = sat_to_32(33'(box_l_ff) - $signed(33'(push_d)));
                                 pos_x_in = sat_to_32(33'(pos_x_ff) - $signed(33'(push_d)));
                                 if (vel_x_ff > 0) vel_x_in = '0;
                              end else begin
                                 box_l_in = sat_to_32(33'(box_l_ff) + $signed(33'(push_d)));
                                 pos_x_in = sat_to_32(33'(pos_x_ff) + $signed(33'(push_d)));
                                 if (vel_x_ff < 0) vel_x_in = '0;
                              end
                           end else begin
                              axis_in = AXIS_VERT;
                              if (dy2_ff > 0) begin
                                 box_t_in = sat_to_32(33'(box_t_ff) - $signed(33'(push_d)));
                                 pos_y_in = sat_to_32(33'(pos_y_ff) - $signed(33'(push_d)));
                                 if (vel_y_ff > 0) vel_y_in = '0;
                              end else begin
                                 box_t_in = sat_to_32(33'(box_t_ff) + $signed(33'(push_d)));
                                 pos_y_in = sat_to_32(33'(pos_y_ff) + $signed(33'(push_d)));
                                 if (vel_y_ff < 0) vel_y_in = '0;
                              end
                           end
                        end
                     end
                  end
                  default: state_in = ST_A;
               endcase
            end
         endcase
      end
   end

   // The result carries the state as it stands after the item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.out_pos_x      = pos_x_in;
         rsp_data_in.out_pos_y      = pos_y_in;
         rsp_data_in.out_vel_x      = vel_x_in;
         rsp_data_in.out_vel_y      = vel_y_in;
         rsp_data_in.out_box_left   = box_l_in;
         rsp_data_in.out_box_top    = box_t_in;
         rsp_data_in.out_box_width  = box_w_in;
         rsp_data_in.out_box_height = box_h_in;
         rsp_data_in.push_axis      = axis_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_A;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         box_l_ff     <= '0;
         box_t_ff     <= '0;
         box_w_ff     <= '0;
         box_h_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         box_l_ff     <= box_l_in;
         box_t_ff     <= box_t_in;
         box_w_ff     <= box_w_in;
         box_h_ff     <= box_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      apart_ff    <= apart_in;
      dx2_ff      <= dx2_in;
      dy2_ff      <= dy2_in;
      sumw_ff     <= sumw_in;
      sumh_ff     <= sumh_in;
      h2_ff       <= h2_in;
      v2_ff       <= v2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/aabb_integrate_and_resolve_unit.sv
// ----------------------------------------------------------------------------
// AABB integrate and resolve unit
// One body's position, velocity and hitbox, stepped and collided per item.
// ----------------------------------------------------------------------------
// Usage: each item on the req_ channel carries an action (set position, set
// velocity, integrate one 1/60 s step, or resolve against another box) and
// its operands. Every item yields exactly one result on the rsp_ channel: the
// full body state after the item plus the axis of any push.
// The front end classifies and pre-scales an item in the cycle it is taken
// and writes it into a short queue; req_stall is high only while that queue
// is full. The back end works from the queue head, its sequencer stepping
// each item: a load finishes in its first state, a resolve runs the overlap
// test, the overlap depths and the push, and an integrate runs the velocity
// update, the multiply of the new velocity, the position update and the box
// update (the multiply must follow the velocity update).
// The result sits in an output register; while rsp_stall is high it holds,
// and the back end finishes its current item only once that register frees,
// so the queue keeps taking items until it fills. Synchronous reset clears
// the body state to zero, the queue and the output, and loads the base size
// 32 by 32 with no reductions. The user must write configuration through
// csr_ while the unit is idle (not enforced); it is used at the next integrate.
module aabb_integrate_and_resolve_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  aair_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output aair_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [aair_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [aair_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import aair_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      queue_full, queue_not_empty, push, pop;
   entry_type push_data, head;

   // Configuration registers; writes to unlisted indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_BASE_WIDTH:    cfg_in.base_width    = csr_wdata[11:0];
            REG_BASE_HEIGHT:   cfg_in.base_height   = csr_wdata[11:0];
            REG_REDUCE_LEFT:   cfg_in.reduce_left   = csr_wdata;
            REG_REDUCE_TOP:    cfg_in.reduce_top    = csr_wdata;
            REG_REDUCE_RIGHT:  cfg_in.reduce_right  = csr_wdata;
            REG_REDUCE_BOTTOM: cfg_in.reduce_bottom = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_width    <= 12'd32;
         cfg_ff.base_height   <= 12'd32;
         cfg_ff.reduce_left   <= '0;
         cfg_ff.reduce_top    <= '0;
         cfg_ff.reduce_right  <= '0;
         cfg_ff.reduce_bottom <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aair_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   aair_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   aair_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (queue_not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
